>>> sv/fpw_pkg.sv
// Shared types, widths, register codes and the channel scaling function
// for the framebuffer pixel writer. No dependencies.
`default_nettype none

package fpw_pkg;

    localparam int FPW_ADDRESS_WIDTH = 32;

    localparam int COORD_W     = 16;
    localparam int LEVEL_W     = 8;
    localparam int ADDR_W      = 32;
    localparam int DATA_W      = 32;
    localparam int BPP_W       = 3;
    localparam int SCREEN_W    = 13;
    localparam int PAN_W       = 12;
    localparam int STRIDE_W    = 16;
    localparam int LAYOUT_W    = 44;
    localparam int CHAN_W      = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 44;

    // row/column plus pan, before scaling to bytes
    localparam int POS_SUM_W   = 14;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_PAN_X         = 3'd2,
        REG_PAN_Y         = 3'd3,
        REG_ROW_STRIDE    = 3'd4,
        REG_BYTES_PER_PIX = 3'd5,
        REG_MEMORY_SIZE   = 3'd6,
        REG_CHANNEL_LAYOUT = 3'd7
    } cfg_reg_t;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [LEVEL_W-1:0]        red_level;
        logic [LEVEL_W-1:0]        green_level;
        logic [LEVEL_W-1:0]        blue_level;
    } pixel_t;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] byte_address;
        logic [DATA_W-1:0] write_data;
        logic [BPP_W-1:0]  byte_count;
    } write_t;

    // round(level * (2^len - 1) / 255), shifted to offset.
    // len = 8k + m. c = level << m = 255a + r, so level*2^len/255 has
    // integer part (a << 8k) | {k bytes of r} and fraction r/255; the
    // rounding constant and the -level term move that by at most one.
    function automatic logic [DATA_W-1:0] scale_level(input logic [LEVEL_W-1:0] level,
                                                      input logic [CHAN_W-1:0] field);
        logic [4:0]  offs;
        logic [5:0]  len_raw;
        logic [5:0]  len;
        logic [2:0]  m;
        logic [2:0]  k;
        logic [14:0] c;
        logic [16:0] sum_a;
        logic [7:0]  a;
        logic [15:0] a255;
        logic [7:0]  r;
        logic [31:0] rep_mask;
        logic [39:0] whole;
        logic [39:0] q;
        logic [8:0]  r_bias;
        logic [8:0]  lvl_hi;
        offs    = field[4:0];
        len_raw = field[10:5];
        len     = (len_raw > 6'd32) ? 6'd32 : len_raw;
        m       = len[2:0];
        k       = len[5:3];
        c       = 15'(level) << m;
        sum_a   = 17'(c) + 17'd1 + 17'(c[14:8]);
        a       = sum_a[15:8];
        a255    = (16'(a) << 8) - 16'(a);
        r       = 8'(16'(c) - a255);
        case (k)
            3'd0:    rep_mask = 32'h0000_0000;
            3'd1:    rep_mask = 32'h0000_00ff;
            3'd2:    rep_mask = 32'h0000_ffff;
            3'd3:    rep_mask = 32'h00ff_ffff;
            default: rep_mask = 32'hffff_ffff;
        endcase
        whole  = (40'(a) << {k, 3'b000}) | 40'({4{r}} & rep_mask);
        r_bias = 9'(r) + 9'd127;
        lvl_hi = 9'(level) + 9'd255;
        if (r_bias < 9'(level))
            q = whole - 40'd1;
        else if (r_bias >= lvl_hi)
            q = whole + 40'd1;
        else
            q = whole;
        if (len == 6'd0)
            return '0;
        return q[DATA_W-1:0] << offs;
    endfunction

endpackage

`default_nettype wire

>>> sv/fpw_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Standalone; payload types come from fpw_pkg at instantiation.
`default_nettype none

interface fpw_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/fpw_color_pack.sv
// Scales the color levels to the configured channel layout and packs them
// into one pixel word, trimmed to the pixel size. Uses fpw_pkg.
`default_nettype none

module fpw_color_pack
    import fpw_pkg::*;
(
    input  logic [LEVEL_W-1:0]  red_level,
    input  logic [LEVEL_W-1:0]  green_level,
    input  logic [LEVEL_W-1:0]  blue_level,
    input  logic [LAYOUT_W-1:0] channel_layout,
    input  logic [BPP_W-1:0]    bytes_per_pixel,
    output logic [DATA_W-1:0]   pixel_word
);

    logic [DATA_W-1:0] red_bits;
    logic [DATA_W-1:0] green_bits;
    logic [DATA_W-1:0] blue_bits;
    logic [DATA_W-1:0] alpha_bits;
    logic [DATA_W-1:0] full_word;

    assign red_bits   = scale_level(red_level,   channel_layout[0*CHAN_W +: CHAN_W]);
    assign green_bits = scale_level(green_level, channel_layout[1*CHAN_W +: CHAN_W]);
    assign blue_bits  = scale_level(blue_level,  channel_layout[2*CHAN_W +: CHAN_W]);
    // alpha is always opaque
    assign alpha_bits = scale_level(8'hff,       channel_layout[3*CHAN_W +: CHAN_W]);
    assign full_word  = red_bits | green_bits | blue_bits | alpha_bits;

    always_comb
    begin
        case (bytes_per_pixel)
            3'd2:    pixel_word = full_word & 32'h0000_ffff;
            3'd3:    pixel_word = full_word & 32'h00ff_ffff;
            default: pixel_word = full_word;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/framebuffer_pixel_writer.sv
// Framebuffer pixel writer: clips a pixel, computes its byte address and
// packed color word. Uses fpw_pkg, fpw_stream_if and fpw_color_pack.
// Pipeline: input reg, then result reg; a stalled result keeps the item in the input reg.
// Throughput: one item per cycle while the output is not stalled; the address
// multiply and color packing sit in the single logic stage between the two registers.
// Reset: async active low; clears valids, all config to 0, bytes_per_pixel 4.
`default_nettype none

module framebuffer_pixel_writer
    import fpw_pkg::*;
#(
    parameter int ADDRESS_WIDTH = FPW_ADDRESS_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    fpw_stream_if.sink             pixel,
    fpw_stream_if.source           pixel_write
);

    localparam int CMP_W = (ADDRESS_WIDTH >= ADDR_W) ? ADDRESS_WIDTH + 1 : ADDR_W + 1;
    localparam logic [CMP_W-1:0] ADDR_LIMIT = CMP_W'(1) << ADDRESS_WIDTH;

    // configuration
    logic [SCREEN_W-1:0] screen_width_reg;
    logic [SCREEN_W-1:0] screen_height_reg;
    logic [PAN_W-1:0]    pan_x_reg;
    logic [PAN_W-1:0]    pan_y_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [BPP_W-1:0]    bpp_reg;
    logic [ADDR_W-1:0]   mem_size_reg;
    logic [LAYOUT_W-1:0] layout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
            pan_x_reg         <= '0;
            pan_y_reg         <= '0;
            stride_reg        <= '0;
            bpp_reg           <= BPP_RESET;
            mem_size_reg      <= '0;
            layout_reg        <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:   screen_width_reg  <= cfg_data[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT:  screen_height_reg <= cfg_data[SCREEN_W-1:0];
                REG_PAN_X:          pan_x_reg         <= cfg_data[PAN_W-1:0];
                REG_PAN_Y:          pan_y_reg         <= cfg_data[PAN_W-1:0];
                REG_ROW_STRIDE:     stride_reg        <= cfg_data[STRIDE_W-1:0];
                REG_BYTES_PER_PIX:  bpp_reg           <= cfg_data[BPP_W-1:0];
                REG_MEMORY_SIZE:    mem_size_reg      <= cfg_data[ADDR_W-1:0];
                REG_CHANNEL_LAYOUT: layout_reg        <= cfg_data[LAYOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic   in_valid_reg;
    pixel_t in_pixel_reg;
    logic   out_valid_reg;
    write_t out_reg;
    write_t result_next;
    logic   out_advance;

    assign out_advance       = !out_valid_reg || pixel_write.ready;
    assign pixel.ready       = !in_valid_reg || out_advance;
    assign pixel_write.valid = out_valid_reg;
    assign pixel_write.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pixel.ready)
                in_valid_reg <= pixel.valid;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
            in_pixel_reg <= pixel.data;
        if (out_advance && in_valid_reg)
            out_reg <= result_next;
    end

    // datapath
    logic                   on_screen;
    logic                   bpp_ok;
    logic [POS_SUM_W-1:0]   col_sum;
    logic [POS_SUM_W-1:0]   row_sum;
    logic [29:0]            row_offset;
    logic [16:0]            col_offset;
    logic [ADDR_W-1:0]      pix_addr;
    logic [ADDR_W-1:0]      end_addr;
    logic                   mem_ok;
    logic                   limit_ok;
    logic                   write_ok;
    logic [DATA_W-1:0]      pixel_word;

    assign on_screen = !in_pixel_reg.pos_x[COORD_W-1] && !in_pixel_reg.pos_y[COORD_W-1]
                       && (in_pixel_reg.pos_x < $signed({3'b000, screen_width_reg}))
                       && (in_pixel_reg.pos_y < $signed({3'b000, screen_height_reg}));
    assign bpp_ok    = (bpp_reg == 3'd2) || (bpp_reg == 3'd3) || (bpp_reg == 3'd4);

    // only the low 13 bits of a clipped coordinate can matter
    assign col_sum    = POS_SUM_W'(in_pixel_reg.pos_x[SCREEN_W-1:0]) + POS_SUM_W'(pan_x_reg);
    assign row_sum    = POS_SUM_W'(in_pixel_reg.pos_y[SCREEN_W-1:0]) + POS_SUM_W'(pan_y_reg);
    assign row_offset = 30'(row_sum) * 30'(stride_reg);
    assign col_offset = 17'(col_sum) * 17'(bpp_reg);
    assign pix_addr   = ADDR_W'(row_offset) + ADDR_W'(col_offset);
    assign end_addr   = pix_addr + ADDR_W'(bpp_reg);
    assign mem_ok     = end_addr <= mem_size_reg;
    assign limit_ok   = CMP_W'(end_addr) <= ADDR_LIMIT;
    assign write_ok   = on_screen && bpp_ok && mem_ok && limit_ok;

    fpw_color_pack u_color_pack (
        .red_level       (in_pixel_reg.red_level),
        .green_level     (in_pixel_reg.green_level),
        .blue_level      (in_pixel_reg.blue_level),
        .channel_layout  (layout_reg),
        .bytes_per_pixel (bpp_reg),
        .pixel_word      (pixel_word)
    );

    always_comb
    begin
        result_next = '0;
        if (write_ok)
        begin
            result_next.write_valid  = 1'b1;
            result_next.byte_address = pix_addr;
            result_next.write_data   = pixel_word;
            result_next.byte_count   = bpp_reg;
        end
    end

    // checks
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.write_valid |->
            (out_reg.byte_count == 3'd2 || out_reg.byte_count == 3'd3
             || out_reg.byte_count == 3'd4))
        else $error("write with illegal byte count");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.write_valid |->
            (out_reg.byte_address == '0 && out_reg.write_data == '0
             && out_reg.byte_count == '0))
        else $error("dropped write carries nonzero fields");

    a_data_trimmed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.byte_count == 3'd2 |-> out_reg.write_data[31:16] == '0)
        else $error("two-byte write has upper data bits set");

    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_advance |=> in_valid_reg && $stable(in_pixel_reg))
        else $error("stalled input stage lost its item");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> pixel.ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
